// File: sv/plqt_pkg.sv
`default_nettype none
package plqt_pkg;

    localparam int PEERS        = 12;
    localparam int COUNTER_BITS = 16;
    localparam int RTT_BITS     = 16;
    localparam int IDX_BITS     = (PEERS > 1) ? $clog2(PEERS) : 1;
    localparam int FAIL_BITS    = 8;
    localparam int GRADE_BITS   = 3;
    localparam int LOSS_BITS    = COUNTER_BITS + 14;
    localparam int ENTRY_BITS   = RTT_BITS + 2 * COUNTER_BITS + FAIL_BITS + GRADE_BITS + 1;
    localparam int CFG_REGS     = 8;

    typedef enum logic [2:0] {
        OP_QUERY   = 3'd0,
        OP_RESET   = 3'd1,
        OP_RST_ALL = 3'd2,
        OP_RTT     = 3'd3,
        OP_SENT    = 3'd4,
        OP_LOST    = 3'd5,
        OP_ATTEMPT = 3'd6,
        OP_ROUTE   = 3'd7
    } op_t;

    localparam logic [2:0] CFG_RTT_EXC  = 3'd0;
    localparam logic [2:0] CFG_RTT_GOOD = 3'd1;
    localparam logic [2:0] CFG_RTT_MOD  = 3'd2;
    localparam logic [2:0] CFG_RTT_POOR = 3'd3;
    localparam logic [2:0] CFG_LOSS_EXC = 3'd4;
    localparam logic [2:0] CFG_LOSS_GOOD = 3'd5;
    localparam logic [2:0] CFG_LOSS_MOD = 3'd6;
    localparam logic [2:0] CFG_LOSS_POOR = 3'd7;

    localparam logic [GRADE_BITS-1:0] GRADE_GOOD = 3'd1;

    typedef struct packed {
        logic [RTT_BITS-1:0]     rtt_avg;
        logic [COUNTER_BITS-1:0] sent;
        logic [COUNTER_BITS-1:0] lost;
        logic [FAIL_BITS-1:0]    fails;
        logic [GRADE_BITS-1:0]   grade;
        logic                    route;
    } entry_t;

    typedef struct packed {
        logic                    start;
        logic [COUNTER_BITS-1:0] lost;
        logic [COUNTER_BITS-1:0] sent;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [LOSS_BITS-1:0] loss;
    } div_rsp_t;

endpackage
`default_nettype wire

// File: sv/plqt_if.sv
`default_nettype none
interface plqt_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] operation;
    logic [3:0] peer_index;
    logic [15:0] rtt_ms;
    logic       flag_bit;
    modport source (output valid, operation, peer_index, rtt_ms, flag_bit, input ready);
    modport sink   (input valid, operation, peer_index, rtt_ms, flag_bit, output ready);
endinterface

interface plqt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  quality_grade;
    logic [13:0] timeout_ms;
    logic [10:0] retry_frames;
    logic        host_routing;
    logic        index_valid;
    modport source (output valid, quality_grade, timeout_ms, retry_frames, host_routing,
                    index_valid, input ready);
    modport sink   (input valid, quality_grade, timeout_ms, retry_frames, host_routing,
                    index_valid, output ready);
endinterface

interface plqt_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: sv/plqt_ram.sv
`default_nettype none
module plqt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// File: sv/plqt_div.sv
`default_nettype none
// Restoring divider, one quotient bit per cycle: loss = lost*10000/sent.
module plqt_div (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire plqt_pkg::div_req_t  req,
    output plqt_pkg::div_rsp_t       rsp
);
    localparam int LB = plqt_pkg::LOSS_BITS;
    localparam int CB = plqt_pkg::COUNTER_BITS;
    localparam int CNT_BITS = $clog2(LB + 1);

    logic [LB-1:0]       quo_reg, quo_next;
    logic [CB:0]         rem_reg, rem_next;
    logic [CB-1:0]       dvs_reg, dvs_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CB:0]         trial;
    logic [LB-1:0]       dividend;

    assign dividend = LB'(req.lost) * LB'(10000);

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[CB-1:0], quo_reg[LB-1]};
        if (req.start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = req.sent;
            cnt_next  = CNT_BITS'(LB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[LB-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next    = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            else
            begin
                rem_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.loss = (dvs_reg == '0) ? '0 : quo_reg;
endmodule
`default_nettype wire

// File: sv/peer_link_quality_tracker_unit.sv
`default_nettype none
// Channel | Dir | Payload
// in      | in  | operation, peer_index, rtt_ms, flag_bit
// out     | out | quality_grade, timeout_ms, retry_frames, host_routing, index_valid
// cfg     | in  | index, data
// Query/sent/attempt/route/reset entry: an item passes the read, modify and output
// states. An RTT sample or lost packet adds the loss division and grade states. Reset
// all and rst_n sweep the table, one entry a cycle, and take no item meanwhile. One
// item at a time; in is ready again once the result beat has been placed in the
// output register.
module peer_link_quality_tracker_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    plqt_in_if.sink      in,
    plqt_out_if.source   out,
    plqt_cfg_if.sink     cfg
);
    localparam int IB = plqt_pkg::IDX_BITS;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_READ  = 7'b0000100,
        ST_MOD   = 7'b0001000,
        ST_DIV   = 7'b0010000,
        ST_GRADE = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic [IB-1:0] clr_reg, clr_next;
    logic [15:0] cfg_reg [plqt_pkg::CFG_REGS];

    logic [2:0]  op_reg;
    logic [3:0]  pidx_reg;
    logic [15:0] rtt_reg;
    logic        flag_reg;
    plqt_pkg::entry_t ent_reg, ent_next;
    logic        ovalid_reg;
    logic [2:0]  og_reg;
    logic [13:0] oto_reg;
    logic [10:0] ort_reg;
    logic        orr_reg, oiv_reg;

    logic        idx_ok;
    logic        wr_en;
    logic [IB-1:0] wr_addr, rd_addr;
    plqt_pkg::entry_t wr_data, rd_data, clear_val;
    plqt_pkg::div_req_t dreq;
    plqt_pkg::div_rsp_t drsp;

    assign idx_ok = 32'(pidx_reg) < plqt_pkg::PEERS;
    assign clear_val = '{rtt_avg: '0, sent: '0, lost: '0, fails: '0,
                         grade: plqt_pkg::GRADE_GOOD, route: 1'b0};

    plqt_ram #(.WIDTH(plqt_pkg::ENTRY_BITS), .DEPTH(plqt_pkg::PEERS)) u_ram (
        .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
        .rd_addr(rd_addr), .rd_data(rd_data)
    );

    plqt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    assign in.ready  = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;
    assign rd_addr   = pidx_reg[IB-1:0];

    function automatic logic [2:0] level(input logic [31:0] v, input logic [31:0] a,
                                         input logic [31:0] b, input logic [31:0] c,
                                         input logic [31:0] d);
        logic [2:0] r;
        begin
            if (v < a) r = 3'd0;
            else if (v < b) r = 3'd1;
            else if (v < c) r = 3'd2;
            else if (v < d) r = 3'd3;
            else r = 3'd4;
            return r;
        end
    endfunction

    logic [2:0]  gr, gl, gsel;
    logic [14:0] tsum;
    logic [13:0] tbase;
    logic [10:0] rbase;
    logic [13:0] rsh;
    logic [1:0]  sh;

    always_comb
    begin
        gr = level(32'(ent_reg.rtt_avg), 32'(cfg_reg[plqt_pkg::CFG_RTT_EXC]),
                   32'(cfg_reg[plqt_pkg::CFG_RTT_GOOD]), 32'(cfg_reg[plqt_pkg::CFG_RTT_MOD]),
                   32'(cfg_reg[plqt_pkg::CFG_RTT_POOR]));
        gl = level(32'(drsp.loss), 32'(cfg_reg[plqt_pkg::CFG_LOSS_EXC][13:0]),
                   32'(cfg_reg[plqt_pkg::CFG_LOSS_GOOD][13:0]),
                   32'(cfg_reg[plqt_pkg::CFG_LOSS_MOD][13:0]),
                   32'(cfg_reg[plqt_pkg::CFG_LOSS_POOR][13:0]));
        gsel = (gr > gl) ? gr : gl;
        case (ent_reg.grade)
            3'd1: begin tbase = 14'd2500; rbase = 11'd180; end
            3'd2: begin tbase = 14'd3000; rbase = 11'd240; end
            3'd3: begin tbase = 14'd4000; rbase = 11'd300; end
            3'd4: begin tbase = 14'd6000; rbase = 11'd420; end
            default: begin tbase = 14'd2000; rbase = 11'd180; end
        endcase
        if (ent_reg.rtt_avg > 16'd4000)
            tsum = 15'd10000;
        else
            tsum = 15'(tbase) + {ent_reg.rtt_avg[13:0], 1'b0};
        sh = (ent_reg.fails > 8'd3) ? 2'd3 : ent_reg.fails[1:0];
        rsh = 14'(rbase) << sh;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ent_next   = ent_reg;
        wr_en      = 1'b0;
        wr_addr    = pidx_reg[IB-1:0];
        wr_data    = ent_reg;
        dreq       = '{start: 1'b0, lost: ent_reg.lost, sent: ent_reg.sent};
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = clear_val;
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == plqt_pkg::PEERS - 1)
                begin
                    clr_next = '0;
                    state_next = (op_reg == plqt_pkg::OP_RST_ALL) ? ST_READ : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in.valid)
                    state_next = (in.operation == plqt_pkg::OP_RST_ALL) ? ST_CLEAR : ST_READ;
            end
            ST_READ:
                state_next = ST_MOD;
            ST_MOD:
            begin
                ent_next = rd_data;
                state_next = ST_OUT;
                if (idx_ok)
                begin
                    case (op_reg)
                        plqt_pkg::OP_RESET: ent_next = clear_val;
                        plqt_pkg::OP_RTT:
                        begin
                            ent_next.rtt_avg = (rd_data.rtt_avg == '0) ? rtt_reg
                                             : 16'((18'(rd_data.rtt_avg) * 18'd3
                                                   + 18'(rtt_reg)) >> 2);
                            state_next = ST_DIV;
                        end
                        plqt_pkg::OP_SENT:
                            if (rd_data.sent != '1) ent_next.sent = rd_data.sent + 1'b1;
                        plqt_pkg::OP_LOST:
                        begin
                            if (rd_data.lost != '1) ent_next.lost = rd_data.lost + 1'b1;
                            state_next = ST_DIV;
                        end
                        plqt_pkg::OP_ATTEMPT:
                            if (flag_reg)
                            begin
                                ent_next.fails = '0;
                                ent_next.route = 1'b0;
                            end
                            else
                            begin
                                if (rd_data.fails != 8'd255)
                                    ent_next.fails = rd_data.fails + 1'b1;
                                if (rd_data.fails >= 8'd2) ent_next.route = 1'b1;
                            end
                        plqt_pkg::OP_ROUTE: ent_next.route = flag_reg;
                        default: ;
                    endcase
                end
            end
            ST_DIV:
            begin
                dreq.start = 1'b1;
                state_next = ST_GRADE;
            end
            ST_GRADE:
            begin
                if (drsp.done)
                begin
                    ent_next.grade = gsel;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                wr_en = idx_ok;
                if (!ovalid_reg || out.ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
            op_reg     <= plqt_pkg::OP_QUERY;
            cfg_reg[plqt_pkg::CFG_RTT_EXC]   <= 16'd50;
            cfg_reg[plqt_pkg::CFG_RTT_GOOD]  <= 16'd100;
            cfg_reg[plqt_pkg::CFG_RTT_MOD]   <= 16'd200;
            cfg_reg[plqt_pkg::CFG_RTT_POOR]  <= 16'd400;
            cfg_reg[plqt_pkg::CFG_LOSS_EXC]  <= 16'd200;
            cfg_reg[plqt_pkg::CFG_LOSS_GOOD] <= 16'd500;
            cfg_reg[plqt_pkg::CFG_LOSS_MOD]  <= 16'd1000;
            cfg_reg[plqt_pkg::CFG_LOSS_POOR] <= 16'd2000;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (in.valid && in.ready)
                op_reg <= in.operation;
            if (cfg.valid)
                cfg_reg[cfg.index] <= (cfg.index >= plqt_pkg::CFG_LOSS_EXC)
                                      ? {2'b00, cfg.data[13:0]} : cfg.data;
            if (state_reg == ST_OUT && (!ovalid_reg || out.ready))
                ovalid_reg <= 1'b1;
            else if (out.ready)
                ovalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
        if (in.valid && in.ready)
        begin
            pidx_reg <= in.peer_index;
            rtt_reg  <= in.rtt_ms;
            flag_reg <= in.flag_bit;
        end
        if (state_reg == ST_OUT && (!ovalid_reg || out.ready))
        begin
            oiv_reg <= idx_ok;
            if (idx_ok)
            begin
                og_reg  <= ent_reg.grade;
                oto_reg <= (tsum > 15'd10000) ? 14'd10000 : tsum[13:0];
                ort_reg <= (rsh > 14'd1800) ? 11'd1800 : rsh[10:0];
                orr_reg <= ent_reg.route;
            end
            else
            begin
                og_reg  <= 3'd2;
                oto_reg <= 14'd2000;
                ort_reg <= 11'd300;
                orr_reg <= 1'b0;
            end
        end
    end

    assign out.valid         = ovalid_reg;
    assign out.quality_grade = og_reg;
    assign out.timeout_ms    = oto_reg;
    assign out.retry_frames  = ort_reg;
    assign out.host_routing  = orr_reg;
    assign out.index_valid   = oiv_reg;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in.ready |-> state_reg == ST_IDLE) else $error("ready outside idle");
    a_div_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        dreq.start |=> state_reg == ST_GRADE) else $error("division lost");
    a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !in.ready) else $error("accept during clear");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out.valid && !out.ready |=> out.valid && $stable(out.timeout_ms))
        else $error("result beat dropped");
`endif
endmodule
`default_nettype wire

// File: sim/tb_peer_link_quality_tracker_unit.sv
`timescale 1ns / 1ps
module tb_peer_link_quality_tracker_unit;

    typedef struct packed {
        plqt_pkg::op_t op;
        logic [3:0]  peer;
        logic [15:0] rtt;
        logic        flag;
    } link_event_t;

    typedef struct packed {
        logic [2:0]  grade;
        logic [13:0] timeout;
        logic [10:0] retry;
        logic        route;
        logic        valid_idx;
    } link_report_t;

    logic clk;
    logic rst_n;

    plqt_in_if  in_ch ();
    plqt_out_if out_ch ();
    plqt_cfg_if cfg_ch ();

    peer_link_quality_tracker_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch.sink),
        .out   (out_ch.source),
        .cfg   (cfg_ch.sink)
    );

    // predictor state
    logic [15:0] limit_tab [8];
    logic [15:0] avg_rtt [plqt_pkg::PEERS];
    logic [15:0] sent_cnt [plqt_pkg::PEERS];
    logic [15:0] lost_cnt [plqt_pkg::PEERS];
    logic [7:0]  fail_cnt [plqt_pkg::PEERS];
    logic [2:0]  grade_tab [plqt_pkg::PEERS];
    logic        route_tab [plqt_pkg::PEERS];

    link_event_t  event_q [$];
    link_report_t report_q [$];
    int           errors;
    int           cycle_cnt;
    bit           calm;
    int           drv_gap;
    int           mon_gap;

    initial begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void clear_peer(int i);
        avg_rtt[i]   = '0;
        sent_cnt[i]  = '0;
        lost_cnt[i]  = '0;
        fail_cnt[i]  = '0;
        grade_tab[i] = 3'd1;
        route_tab[i] = 1'b0;
    endfunction

    function automatic logic [2:0] level(longint v, int first);
        if (v < limit_tab[first])     return 3'd0;
        if (v < limit_tab[first + 1]) return 3'd1;
        if (v < limit_tab[first + 2]) return 3'd2;
        if (v < limit_tab[first + 3]) return 3'd3;
        return 3'd4;
    endfunction

    function automatic logic [2:0] rate_peer(int i);
        longint loss;
        logic [2:0] gr;
        logic [2:0] gl;
        loss = 0;
        if (sent_cnt[i] != 0)
            loss = (longint'(lost_cnt[i]) * 10000) / sent_cnt[i];
        gr = level(avg_rtt[i], int'(plqt_pkg::CFG_RTT_EXC));
        gl = level(loss, int'(plqt_pkg::CFG_LOSS_EXC));
        return (gr > gl) ? gr : gl;
    endfunction

    function automatic link_report_t apply_event(link_event_t ev);
        link_report_t r;
        int i;
        int tmo;
        int rty;
        int sh;
        if (ev.op == plqt_pkg::OP_RST_ALL)
            for (int k = 0; k < plqt_pkg::PEERS; k++) clear_peer(k);
        if (ev.peer >= plqt_pkg::PEERS) begin
            r.grade = 3'd2;
            r.timeout = 14'd2000;
            r.retry = 11'd300;
            r.route = 1'b0;
            r.valid_idx = 1'b0;
            return r;
        end
        i = ev.peer;
        case (ev.op)
            plqt_pkg::OP_RESET: clear_peer(i);
            plqt_pkg::OP_RTT: begin
                if (avg_rtt[i] == 0) avg_rtt[i] = ev.rtt;
                else avg_rtt[i] = 16'((32'(avg_rtt[i]) * 3 + ev.rtt) / 4);
                grade_tab[i] = rate_peer(i);
            end
            plqt_pkg::OP_SENT: if (sent_cnt[i] != 16'hFFFF) sent_cnt[i]++;
            plqt_pkg::OP_LOST: begin
                if (lost_cnt[i] != 16'hFFFF) lost_cnt[i]++;
                grade_tab[i] = rate_peer(i);
            end
            plqt_pkg::OP_ATTEMPT: begin
                if (ev.flag) begin
                    fail_cnt[i] = '0;
                    route_tab[i] = 1'b0;
                end else begin
                    if (fail_cnt[i] != 8'd255) fail_cnt[i]++;
                    if (fail_cnt[i] >= 3) route_tab[i] = 1'b1;
                end
            end
            plqt_pkg::OP_ROUTE: route_tab[i] = ev.flag;
            default: ;
        endcase
        case (grade_tab[i])
            3'd0: begin tmo = 2000; rty = 180; end
            3'd1: begin tmo = 2500; rty = 180; end
            3'd2: begin tmo = 3000; rty = 240; end
            3'd3: begin tmo = 4000; rty = 300; end
            3'd4: begin tmo = 6000; rty = 420; end
            default: begin tmo = 2000; rty = 180; end
        endcase
        tmo = tmo + 2 * avg_rtt[i];
        if (tmo > 10000) tmo = 10000;
        sh = (fail_cnt[i] > 3) ? 3 : fail_cnt[i];
        rty = rty << sh;
        if (rty > 1800) rty = 1800;
        r.grade = grade_tab[i];
        r.timeout = 14'(tmo);
        r.retry = 11'(rty);
        r.route = route_tab[i];
        r.valid_idx = 1'b1;
        return r;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.operation <= '0;
            in_ch.peer_index <= '0;
            in_ch.rtt_ms <= '0;
            in_ch.flag_bit <= 1'b0;
            drv_gap <= 0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                report_q.push_back(apply_event(link_event_t'({in_ch.operation,
                    in_ch.peer_index, in_ch.rtt_ms, in_ch.flag_bit})));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 9) == 0) begin
                    drv_gap <= $urandom_range(0, 8);
                    in_ch.valid <= 1'b0;
                end else if (event_q.size() > 0) begin
                    link_event_t ev;
                    ev = event_q.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.operation <= ev.op;
                    in_ch.peer_index <= ev.peer;
                    in_ch.rtt_ms <= ev.rtt;
                    in_ch.flag_bit <= ev.flag;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            mon_gap <= 0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected result beat grade=%0d", $time,
                        out_ch.quality_grade);
                    errors++;
                end else begin
                    link_report_t exp_r;
                    exp_r = report_q.pop_front();
                    if (exp_r.grade !== out_ch.quality_grade) begin
                        $display("%0t: grade exp %0d got %0d", $time, exp_r.grade,
                            out_ch.quality_grade);
                        errors++;
                    end
                    if (exp_r.timeout !== out_ch.timeout_ms) begin
                        $display("%0t: timeout exp %0d got %0d", $time, exp_r.timeout,
                            out_ch.timeout_ms);
                        errors++;
                    end
                    if (exp_r.retry !== out_ch.retry_frames) begin
                        $display("%0t: retry exp %0d got %0d", $time, exp_r.retry,
                            out_ch.retry_frames);
                        errors++;
                    end
                    if (exp_r.route !== out_ch.host_routing) begin
                        $display("%0t: routing exp %0d got %0d", $time, exp_r.route,
                            out_ch.host_routing);
                        errors++;
                    end
                    if (exp_r.valid_idx !== out_ch.index_valid) begin
                        $display("%0t: index_valid exp %0d got %0d", $time,
                            exp_r.valid_idx, out_ch.index_valid);
                        errors++;
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                mon_gap <= $urandom_range(0, 8);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 400000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic push_event(plqt_pkg::op_t op, int peer, int rtt, bit flag);
        link_event_t ev;
        ev.op = op;
        ev.peer = 4'(peer);
        ev.rtt = 16'(rtt);
        ev.flag = flag;
        event_q.push_back(ev);
    endtask

    task automatic drain();
        while (event_q.size() > 0 || report_q.size() > 0 || in_ch.valid)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic write_limit(logic [2:0] idx, int value);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= 16'(value);
        do @(posedge clk); while (!cfg_ch.ready);
        limit_tab[idx] = (idx < plqt_pkg::CFG_LOSS_EXC) ? 16'(value)
                                                        : 16'(value & 16'h3FFF);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_burst(int n);
        int peer;
        int pick;
        for (int k = 0; k < n; k++) begin
            peer = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 15)
                                               : $urandom_range(0, 3);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                push_event(plqt_pkg::OP_SENT, peer, $urandom, $urandom_range(0, 1));
            else if (pick < 40)
                push_event(plqt_pkg::OP_LOST, peer, $urandom, $urandom_range(0, 1));
            else if (pick < 60)
                push_event(plqt_pkg::OP_RTT, peer, ($urandom_range(0, 3) == 0) ? $urandom
                           : $urandom_range(0, 600), $urandom_range(0, 1));
            else if (pick < 75)
                push_event(plqt_pkg::OP_ATTEMPT, peer, $urandom, $urandom_range(0, 2) == 0);
            else if (pick < 82)
                push_event(plqt_pkg::OP_ROUTE, peer, $urandom, $urandom_range(0, 1));
            else if (pick < 95)
                push_event(plqt_pkg::OP_QUERY, peer, $urandom, $urandom_range(0, 1));
            else if (pick < 98)
                push_event(plqt_pkg::OP_RESET, peer, $urandom, $urandom_range(0, 1));
            else
                push_event(plqt_pkg::OP_RST_ALL, peer, $urandom, $urandom_range(0, 1));
        end
    endtask

    initial begin
        errors = 0;
        cycle_cnt = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = plqt_pkg::CFG_RTT_EXC;
        cfg_ch.data = '0;
        limit_tab = '{16'd50, 16'd100, 16'd200, 16'd400,
                      16'd200, 16'd500, 16'd1000, 16'd2000};
        for (int k = 0; k < plqt_pkg::PEERS; k++) clear_peer(k);
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: each operation, extremes, out-of-range peers
        push_event(plqt_pkg::OP_QUERY, 0, 0, 0);
        push_event(plqt_pkg::OP_QUERY, 15, 16'hFFFF, 1);
        push_event(plqt_pkg::OP_RTT, 1, 16'hFFFF, 0);
        push_event(plqt_pkg::OP_RTT, 1, 0, 1);
        push_event(plqt_pkg::OP_RTT, 2, 30, 0);
        push_event(plqt_pkg::OP_SENT, 2, 0, 0);
        push_event(plqt_pkg::OP_LOST, 2, 0, 0);
        push_event(plqt_pkg::OP_LOST, 2, 0, 0);
        push_event(plqt_pkg::OP_LOST, 3, 0, 0);
        for (int k = 0; k < 4; k++) push_event(plqt_pkg::OP_ATTEMPT, 4, 0, 0);
        push_event(plqt_pkg::OP_ATTEMPT, 4, 0, 1);
        push_event(plqt_pkg::OP_ROUTE, 5, 0, 1);
        push_event(plqt_pkg::OP_ROUTE, 5, 0, 0);
        push_event(plqt_pkg::OP_ROUTE, 12, 0, 1);
        push_event(plqt_pkg::OP_RESET, 2, 0, 0);
        push_event(plqt_pkg::OP_RST_ALL, 13, 0, 0);
        push_event(plqt_pkg::OP_QUERY, 11, 0, 0);
        drain();

        // saturate the fail count
        for (int k = 0; k < 300; k++) push_event(plqt_pkg::OP_ATTEMPT, 6, 0, 0);
        drain();

        random_burst(170);
        drain();
        write_limit(plqt_pkg::CFG_RTT_EXC, 0);
        write_limit(plqt_pkg::CFG_RTT_GOOD, 16'hFFFF);
        write_limit(plqt_pkg::CFG_RTT_MOD, 16'hFFFF);
        write_limit(plqt_pkg::CFG_RTT_POOR, 16'hFFFF);
        write_limit(plqt_pkg::CFG_LOSS_EXC, 0);
        write_limit(plqt_pkg::CFG_LOSS_GOOD, 10000);
        write_limit(plqt_pkg::CFG_LOSS_MOD, 16'hFFFF);
        write_limit(plqt_pkg::CFG_LOSS_POOR, 16'h3FFF);
        random_burst(170);
        drain();
        for (int r = 0; r < 8; r++)
            write_limit(r[2:0], $urandom_range(0, (r < 4) ? 700 : 4000));
        random_burst(170);
        drain();
        write_limit(plqt_pkg::CFG_RTT_EXC, 50);
        write_limit(plqt_pkg::CFG_RTT_GOOD, 100);
        write_limit(plqt_pkg::CFG_RTT_MOD, 200);
        write_limit(plqt_pkg::CFG_RTT_POOR, 400);
        write_limit(plqt_pkg::CFG_LOSS_EXC, 200);
        write_limit(plqt_pkg::CFG_LOSS_GOOD, 500);
        write_limit(plqt_pkg::CFG_LOSS_MOD, 1000);
        write_limit(plqt_pkg::CFG_LOSS_POOR, 2000);
        calm = 1'b1;
        random_burst(170);
        drain();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
